// ----- hw/rtl/ped_pkg.sv -----
package ped_pkg;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // Up to three decoded characters per item, each line feed may add a carriage return
    localparam int unsigned DEC_MAX = 3;
    localparam int unsigned RES_MAX = 4;
    localparam int unsigned DEC_CNT_W = $clog2(DEC_MAX + 1);
    localparam int unsigned RES_CNT_W = $clog2(RES_MAX + 1);
    localparam int unsigned RES_IDX_W = $clog2(RES_MAX);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } ped_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } ped_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } ped_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } ped_hex_t;

    // Classify one character as a hex digit and give its value
    function automatic ped_hex_t hex_val(input logic [7:0] c);
        ped_hex_t h;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.nib = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.ok  = 1'b1;
            h.nib = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// ----- hw/rtl/percent_escape_decoder.sv -----
// Percent-escape decoder for URL strings.
//
// enc channel: one character per beat (in_byte), is_final on the last
// character of a string. dec channel: decoded characters, run_last on the
// last character caused by one enc beat, string_end on the last character
// of the string. Both channels are valid/ready.
//
// An accepted beat is held in an input register, is decoded in one pass
// into a four-entry result register, and its characters are offered on
// dec from the result register. An enc beat that yields zero or one
// character lets the block sustain one beat per cycle while dec is ready;
// a beat yielding several characters holds the result register while
// they drain. The next beat is decoded in the same cycle the last
// character of the previous one is taken.
//
// Reset clears the escape phase, the carriage-return tracking and both
// registers to empty. When dec stalls, the current character holds, the
// input register fills and then enc_ready drops until dec moves again.
module percent_escape_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    output logic              enc_ready,
    input  ped_pkg::ped_in_t  enc_beat,
    output logic              dec_valid,
    input  logic              dec_ready,
    output ped_pkg::ped_out_t dec_beat
);

    localparam int unsigned DCW = ped_pkg::DEC_CNT_W;
    localparam int unsigned RCW = ped_pkg::RES_CNT_W;
    localparam int unsigned RIW = ped_pkg::RES_IDX_W;

    logic                 in_full_reg;
    ped_pkg::ped_in_t     in_reg;

    ped_pkg::ped_phase_t  phase_reg, phase_next;
    logic [7:0]           held_reg, held_next;
    logic                 prev_cr_reg, prev_cr_next;

    logic [7:0]           dec_byte [ped_pkg::DEC_MAX];
    logic [DCW-1:0]       dec_n;

    logic [7:0]           res_reg  [ped_pkg::RES_MAX];
    logic [7:0]           res_next [ped_pkg::RES_MAX];
    logic [RCW-1:0]       cnt_reg, cnt_next;
    logic [RCW-1:0]       rd_idx_reg;
    logic                 fin_reg;

    logic                 out_empty;
    logic                 last_beat;
    logic                 move;
    logic                 enc_fire;
    logic                 dec_fire;

    // Result register occupancy and hand-off from the input register
    assign out_empty = (rd_idx_reg == cnt_reg);
    assign last_beat = ((rd_idx_reg + RCW'(1)) == cnt_reg);
    assign move      = in_full_reg && (out_empty || (last_beat && dec_ready));
    assign enc_ready = !in_full_reg || move;
    assign enc_fire  = enc_valid && enc_ready;
    assign dec_fire  = dec_valid && dec_ready;

    // Escape phase: next phase, held digit and the decoded characters
    always_comb
    begin
        ped_pkg::ped_hex_t hb;
        ped_pkg::ped_hex_t hh;
        logic [7:0]        b;
        b          = in_reg.in_byte;
        hb         = ped_pkg::hex_val(b);
        hh         = ped_pkg::hex_val(held_reg);
        phase_next = ped_pkg::PH_IDLE;
        held_next  = held_reg;
        dec_n      = '0;
        for (int i = 0; i < ped_pkg::DEC_MAX; i++)
        begin
            dec_byte[i] = 8'h00;
        end

        case (phase_reg)
            ped_pkg::PH_PCT:
            begin
                if (hb.ok)
                begin
                    phase_next = ped_pkg::PH_DIGIT;
                    held_next  = b;
                end
                else
                begin
                    dec_byte[dec_n] = ped_pkg::CH_PERCENT;
                    dec_n = dec_n + DCW'(1);
                    if (b == ped_pkg::CH_PERCENT)
                    begin
                        phase_next = ped_pkg::PH_PCT;
                    end
                    else
                    begin
                        dec_byte[dec_n] = b;
                        dec_n = dec_n + DCW'(1);
                    end
                end
            end
            ped_pkg::PH_DIGIT:
            begin
                if (hb.ok)
                begin
                    dec_byte[dec_n] = {hh.nib, hb.nib};
                    dec_n = dec_n + DCW'(1);
                end
                else
                begin
                    dec_byte[dec_n] = ped_pkg::CH_PERCENT;
                    dec_n = dec_n + DCW'(1);
                    dec_byte[dec_n] = held_reg;
                    dec_n = dec_n + DCW'(1);
                    if (b == ped_pkg::CH_PERCENT)
                    begin
                        phase_next = ped_pkg::PH_PCT;
                    end
                    else
                    begin
                        dec_byte[dec_n] = b;
                        dec_n = dec_n + DCW'(1);
                    end
                end
            end
            default:
            begin
                if (b == ped_pkg::CH_PERCENT)
                begin
                    phase_next = ped_pkg::PH_PCT;
                end
                else
                begin
                    dec_byte[dec_n] = b;
                    dec_n = dec_n + DCW'(1);
                end
            end
        endcase

        // Flush a pending escape literally at string end
        if (in_reg.is_final)
        begin
            if (phase_next == ped_pkg::PH_PCT)
            begin
                dec_byte[dec_n] = ped_pkg::CH_PERCENT;
                dec_n = dec_n + DCW'(1);
            end
            else if (phase_next == ped_pkg::PH_DIGIT)
            begin
                dec_byte[dec_n] = ped_pkg::CH_PERCENT;
                dec_n = dec_n + DCW'(1);
                dec_byte[dec_n] = held_next;
                dec_n = dec_n + DCW'(1);
            end
            phase_next = ped_pkg::PH_IDLE;
        end
    end

    // Insert a carriage return before each line feed that lacks one
    always_comb
    begin
        logic           cr;
        logic [RCW-1:0] n;
        cr = prev_cr_reg;
        n  = '0;
        for (int i = 0; i < ped_pkg::RES_MAX; i++)
        begin
            res_next[i] = 8'h00;
        end
        for (int i = 0; i < ped_pkg::DEC_MAX; i++)
        begin
            if (DCW'(i) < dec_n)
            begin
                if (dec_byte[i] == ped_pkg::CH_LF && !cr)
                begin
                    res_next[n[RIW-1:0]] = ped_pkg::CH_CR;
                    n = n + RCW'(1);
                end
                res_next[n[RIW-1:0]] = dec_byte[i];
                n  = n + RCW'(1);
                cr = (dec_byte[i] == ped_pkg::CH_CR);
            end
        end
        cnt_next     = n;
        prev_cr_next = in_reg.is_final ? 1'b0 : cr;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            phase_reg   <= ped_pkg::PH_IDLE;
            prev_cr_reg <= 1'b0;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (enc_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (move)
            begin
                in_full_reg <= 1'b0;
            end

            if (move)
            begin
                phase_reg   <= phase_next;
                prev_cr_reg <= prev_cr_next;
                cnt_reg     <= cnt_next;
                rd_idx_reg  <= '0;
            end
            else if (dec_fire)
            begin
                rd_idx_reg <= rd_idx_reg + RCW'(1);
            end
        end
    end

    // Payload: capture the beat, load the results
    always_ff @(posedge clk)
    begin
        if (enc_fire)
        begin
            in_reg <= enc_beat;
        end
        if (move)
        begin
            held_reg <= held_next;
            fin_reg  <= in_reg.is_final;
            for (int i = 0; i < ped_pkg::RES_MAX; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    // Drive the current result
    assign dec_valid           = !out_empty;
    assign dec_beat.out_byte   = res_reg[rd_idx_reg[RIW-1:0]];
    assign dec_beat.run_last   = last_beat;
    assign dec_beat.string_end = last_beat && fin_reg;

endmodule

// ----- hw/rtl/ped_checker.sv -----
module ped_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              enc_valid,
    input logic              enc_ready,
    input ped_pkg::ped_in_t  enc_beat,
    input logic              dec_valid,
    input logic              dec_ready,
    input ped_pkg::ped_out_t dec_beat
);

    logic       dec_fire;
    logic       prev_cr_reg;
    logic [1:0] beats_reg;

    assign dec_fire = dec_valid && dec_ready;

    // Track the last delivered character and beats within one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cr_reg <= 1'b0;
            beats_reg   <= 2'd0;
        end
        else if (dec_fire)
        begin
            prev_cr_reg <= dec_beat.string_end ? 1'b0 : (dec_beat.out_byte == ped_pkg::CH_CR);
            beats_reg   <= dec_beat.run_last ? 2'd0 : beats_reg + 2'd1;
        end
    end

    // Hold a waiting enc beat
    a_enc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && !enc_ready |=> enc_valid && $stable(enc_beat))
        else $error("enc beat changed while waiting");

    // Hold a stalled result
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(dec_beat))
        else $error("dec beat changed while stalled");

    // Every delivered line feed follows a carriage return
    a_lf_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire && dec_beat.out_byte == ped_pkg::CH_LF |-> prev_cr_reg)
        else $error("line feed without preceding carriage return");

    // No item yields more than four characters
    a_max_beats: assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire && beats_reg == 2'd3 |-> dec_beat.run_last)
        else $error("more than four results for one item");

    // String end closes the item's run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_beat.string_end |-> dec_beat.run_last)
        else $error("string_end without run_last");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (.*);
